// File: design/ipv4_dap_pkg.sv
// Types, codes and character helpers for the IPv4 dotted address parser.
// No dependencies; used by ipv4_dotted_address_parser.
`default_nettype none

package ipv4_dap_pkg;

   localparam int unsigned CharWidth = 8;
   localparam int unsigned AddrWidth = 32;
   localparam int unsigned EarlierParts = 3;

   localparam logic [AddrWidth-1:0] Limit2Parts = 32'h00ff_ffff;
   localparam logic [AddrWidth-1:0] Limit3Parts = 32'h0000_ffff;
   localparam logic [AddrWidth-1:0] LimitByte = 32'h0000_00ff;

   localparam logic [CharWidth-1:0] ChNul = 8'h00;
   localparam logic [CharWidth-1:0] ChDot = 8'h2e;
   localparam logic [CharWidth-1:0] ChZero = 8'h30;
   localparam logic [CharWidth-1:0] ChSeven = 8'h37;
   localparam logic [CharWidth-1:0] ChOne = 8'h31;
   localparam logic [CharWidth-1:0] ChNine = 8'h39;
   localparam logic [CharWidth-1:0] ChLowerX = 8'h78;
   localparam logic [CharWidth-1:0] ChUpperX = 8'h58;

   localparam logic [4:0] NotDigit = 5'd16;

   typedef enum logic [1:0] {
      RADIX_DEC = 2'd0,
      RADIX_OCT = 2'd1,
      RADIX_HEX = 2'd2
   } radix_type;

   typedef enum logic [1:0] {
      DIG_NONE  = 2'd0,
      DIG_ZERO  = 2'd1,
      DIG_XPEND = 2'd2,
      DIG_SEEN  = 2'd3
   } digit_type;

   typedef enum logic [1:0] {
      PH_PARSE  = 2'd0,
      PH_ENDED  = 2'd1,
      PH_FAILED = 2'd2
   } phase_type;

   function automatic logic is_blank(input logic [CharWidth-1:0] c);
      return (c == 8'd32) || (c >= 8'd9 && c <= 8'd13);
   endfunction

   function automatic logic [4:0] digit_value(input logic [CharWidth-1:0] c);
      logic [4:0] v;
      v = NotDigit;
      if (c >= 8'h30 && c <= 8'h39) begin
         v = 5'(c - 8'h30);
      end else if (c >= 8'h61 && c <= 8'h66) begin
         v = 5'(c - 8'h57);
      end else if (c >= 8'h41 && c <= 8'h46) begin
         v = 5'(c - 8'h37);
      end
      return v;
   endfunction

endpackage

`default_nettype wire

// File: design/ipv4_dotted_address_parser.sv
// An accepted NUL is registered in s1, then its result on rsp_*, held while stalled.
// Throughput: one character per cycle; a NUL stalls only while a result is still held.
// Other characters update the parse state and give no transaction.
// Reset (synchronous, active high) empties both registers and returns the parse state
// to its start: no parts, decimal radix, no digits, parsing.
// Depends on ipv4_dap_pkg.
`default_nettype none

module ipv4_dotted_address_parser (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [7:0]  req_ch,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [31:0]      rsp_address,
   output logic             rsp_valid_res
);

   logic                                s1_valid_ff;
   logic [ipv4_dap_pkg::CharWidth-1:0]  s1_ch_ff;
   logic                                advance;
   logic                                is_nul;

   logic [7:0]                          parts_ff [ipv4_dap_pkg::EarlierParts];
   logic [ipv4_dap_pkg::AddrWidth-1:0]  acc_ff, acc_in;
   ipv4_dap_pkg::radix_type             radix_ff, radix_in;
   ipv4_dap_pkg::digit_type             digit_ff, digit_in;
   logic [1:0]                          index_ff, index_in;
   ipv4_dap_pkg::phase_type             phase_ff, phase_in;
   logic                                store_part;

   logic                                rsp_valid_ff, rsp_valid_in;
   logic [ipv4_dap_pkg::AddrWidth-1:0]  rsp_address_ff, fin_addr;
   logic                                rsp_valid_res_ff, fin_ok;

   logic [4:0]                          dv;
   logic                                blank;
   logic                                do_eop;
   logic                                in_radix;
   logic [35:0]                         scaled;
   logic [35:0]                         wide;

   assign is_nul  = (s1_ch_ff == ipv4_dap_pkg::ChNul);
   assign advance = s1_valid_ff && !(is_nul && rsp_valid_ff && rsp_stall);
   assign req_stall = s1_valid_ff && !advance;

   assign dv    = ipv4_dap_pkg::digit_value(s1_ch_ff);
   assign blank = ipv4_dap_pkg::is_blank(s1_ch_ff);

   always_comb begin
      case (radix_ff)
         ipv4_dap_pkg::RADIX_OCT: begin
            in_radix = (dv < 5'd8);
            scaled   = {1'b0, acc_ff, 3'b000};
         end
         ipv4_dap_pkg::RADIX_HEX: begin
            in_radix = (dv < 5'd16);
            scaled   = {acc_ff, 4'b0000};
         end
         default: begin
            in_radix = (dv < 5'd10);
            scaled   = {1'b0, acc_ff, 3'b000} + {3'b000, acc_ff, 1'b0};
         end
      endcase
      wide = scaled + {32'd0, dv[3:0]};
   end

   always_comb begin
      fin_ok = (phase_ff == ipv4_dap_pkg::PH_ENDED) ||
               (phase_ff == ipv4_dap_pkg::PH_PARSE &&
                (digit_ff == ipv4_dap_pkg::DIG_ZERO || digit_ff == ipv4_dap_pkg::DIG_SEEN));
      fin_addr = acc_ff;
      case (index_ff)
         2'd0: fin_addr = acc_ff;
         2'd1: begin
            if (acc_ff > ipv4_dap_pkg::Limit2Parts) fin_ok = 1'b0;
            fin_addr = {parts_ff[0], acc_ff[23:0]};
         end
         2'd2: begin
            if (acc_ff > ipv4_dap_pkg::Limit3Parts) fin_ok = 1'b0;
            fin_addr = {parts_ff[0], parts_ff[1], acc_ff[15:0]};
         end
         default: begin
            if (acc_ff > ipv4_dap_pkg::LimitByte) fin_ok = 1'b0;
            fin_addr = {parts_ff[0], parts_ff[1], parts_ff[2], acc_ff[7:0]};
         end
      endcase
      if (!fin_ok) fin_addr = '0;
   end

   always_comb begin
      acc_in     = acc_ff;
      radix_in   = radix_ff;
      digit_in   = digit_ff;
      index_in   = index_ff;
      phase_in   = phase_ff;
      store_part = 1'b0;
      do_eop     = 1'b0;
      if (is_nul) begin
         acc_in   = '0;
         radix_in = ipv4_dap_pkg::RADIX_DEC;
         digit_in = ipv4_dap_pkg::DIG_NONE;
         index_in = 2'd0;
         phase_in = ipv4_dap_pkg::PH_PARSE;
      end else if (phase_ff == ipv4_dap_pkg::PH_PARSE) begin
         unique case (digit_ff)
            ipv4_dap_pkg::DIG_NONE: begin
               if (blank) begin
                  acc_in = acc_ff;
               end else if (s1_ch_ff == ipv4_dap_pkg::ChZero) begin
                  acc_in   = '0;
                  radix_in = ipv4_dap_pkg::RADIX_OCT;
                  digit_in = ipv4_dap_pkg::DIG_ZERO;
               end else if (s1_ch_ff >= ipv4_dap_pkg::ChOne &&
                            s1_ch_ff <= ipv4_dap_pkg::ChNine) begin
                  acc_in   = {28'd0, dv[3:0]};
                  radix_in = ipv4_dap_pkg::RADIX_DEC;
                  digit_in = ipv4_dap_pkg::DIG_SEEN;
               end else begin
                  phase_in = ipv4_dap_pkg::PH_FAILED;
               end
            end
            ipv4_dap_pkg::DIG_ZERO: begin
               if (s1_ch_ff == ipv4_dap_pkg::ChLowerX || s1_ch_ff == ipv4_dap_pkg::ChUpperX) begin
                  radix_in = ipv4_dap_pkg::RADIX_HEX;
                  digit_in = ipv4_dap_pkg::DIG_XPEND;
               end else if (s1_ch_ff >= ipv4_dap_pkg::ChZero &&
                            s1_ch_ff <= ipv4_dap_pkg::ChSeven) begin
                  acc_in   = {28'd0, dv[3:0]};
                  digit_in = ipv4_dap_pkg::DIG_SEEN;
               end else begin
                  do_eop = 1'b1;
               end
            end
            ipv4_dap_pkg::DIG_XPEND: begin
               if (dv != ipv4_dap_pkg::NotDigit) begin
                  acc_in   = {28'd0, dv[3:0]};
                  digit_in = ipv4_dap_pkg::DIG_SEEN;
               end else begin
                  phase_in = ipv4_dap_pkg::PH_FAILED;
               end
            end
            default: begin
               if (in_radix) begin
                  if (|wide[35:32]) begin
                     phase_in = ipv4_dap_pkg::PH_FAILED;
                  end else begin
                     acc_in = wide[31:0];
                  end
               end else begin
                  do_eop = 1'b1;
               end
            end
         endcase
         if (do_eop) begin
            if (s1_ch_ff == ipv4_dap_pkg::ChDot) begin
               if (index_ff == 2'd3 || acc_ff > ipv4_dap_pkg::LimitByte) begin
                  phase_in = ipv4_dap_pkg::PH_FAILED;
               end else begin
                  store_part = 1'b1;
                  index_in   = index_ff + 2'd1;
                  acc_in     = '0;
                  radix_in   = ipv4_dap_pkg::RADIX_DEC;
                  digit_in   = ipv4_dap_pkg::DIG_NONE;
               end
            end else if (blank) begin
               phase_in = ipv4_dap_pkg::PH_ENDED;
            end else begin
               phase_in = ipv4_dap_pkg::PH_FAILED;
            end
         end
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (advance && is_nul) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         acc_ff       <= '0;
         radix_ff     <= ipv4_dap_pkg::RADIX_DEC;
         digit_ff     <= ipv4_dap_pkg::DIG_NONE;
         index_ff     <= 2'd0;
         phase_ff     <= ipv4_dap_pkg::PH_PARSE;
         for (int i = 0; i < ipv4_dap_pkg::EarlierParts; i++) begin
            parts_ff[i] <= '0;
         end
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (!req_stall) begin
            s1_valid_ff <= req_valid;
         end
         if (advance) begin
            acc_ff   <= acc_in;
            radix_ff <= radix_in;
            digit_ff <= digit_in;
            index_ff <= index_in;
            phase_ff <= phase_in;
            if (is_nul) begin
               for (int i = 0; i < ipv4_dap_pkg::EarlierParts; i++) begin
                  parts_ff[i] <= '0;
               end
            end else if (store_part) begin
               parts_ff[index_ff] <= acc_ff[7:0];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         s1_ch_ff <= req_ch;
      end
      if (advance && is_nul) begin
         rsp_address_ff   <= fin_addr;
         rsp_valid_res_ff <= fin_ok;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_address   = rsp_address_ff;
   assign rsp_valid_res = rsp_valid_res_ff;

endmodule

`default_nettype wire

// File: design/ipv4_dap_checker.sv
// Port-level checker for ipv4_dotted_address_parser, bound to the top level.
// Depends on the top level's ports only.
`default_nettype none

module ipv4_dap_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_valid,
   input wire logic        req_stall,
   input wire logic [7:0]  req_ch,
   input wire logic        rsp_valid,
   input wire logic        rsp_stall,
   input wire logic [31:0] rsp_address,
   input wire logic        rsp_valid_res
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_address) && $stable(rsp_valid_res))
      else $error("held transaction changed while stalled");

   a_invalid_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_valid_res |-> rsp_address == 32'd0)
      else $error("invalid address is not zero");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid && !req_stall)
      else $error("registers not empty after reset");

   a_stall_needs_result: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("input stalled while result side is free");

endmodule

bind ipv4_dotted_address_parser ipv4_dap_checker u_ipv4_dap_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_valid),
   .req_stall     (req_stall),
   .req_ch        (req_ch),
   .rsp_valid     (rsp_valid),
   .rsp_stall     (rsp_stall),
   .rsp_address   (rsp_address),
   .rsp_valid_res (rsp_valid_res)
);

`default_nettype wire
